// ===== hw/rtl/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// shared types, operation and status codes and the ordering compare for the
// binary heap priority queue
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_POP    = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic [OP_W-1:0] operation;
		value_t          value;
	} req_t;

	typedef struct packed {
		value_t              top_value;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// true when a belongs above b: mode 0 smaller on top, mode 1 larger on top
	function automatic logic ranks_above(input logic mode, input value_t a, input value_t b);
		logic res;
		res = mode ? (a > b) : (a < b);
		return res;
	endfunction

endpackage

// ===== hw/rtl/bhpq_if.sv =====
// ----------------------------------------------------------------------------
// bhpq channel interfaces
// valid/ready channels for operation items, result items and the mode write
// ----------------------------------------------------------------------------
interface bhpq_req_if;
	logic            valid;
	logic            ready;
	bhpq_pkg::req_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bhpq_rsp_if;
	logic            valid;
	logic            ready;
	bhpq_pkg::rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bhpq_cfg_if;
	logic valid;
	logic ready;
	logic order_mode;

	modport source (output valid, output order_mode, input ready);
	modport sink   (input valid, input order_mode, output ready);
endinterface

// ===== hw/rtl/binary_heap_priority_queue_core.sv =====
// insert: the element climbs one level per parent read and compare, stopping at the root
//   or when a compare stops the climb, and is then placed in its hole
// pop: the last element refills the root and descends one level per child read and compare
//   until a leaf or a stopping compare; clear, refused items and last-element pop go
//   straight to done; one item at a time, ready again once the result is loaded;
//   a stalled result holds the block in its done state
// reset clears the element count, mode and handshake state; no clearing pass
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// array-based binary heap with insert/sift-up, pop/sift-down and clear,
// min or max ordering selected by the mode register
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_core #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	bhpq_req_if.sink    req,
	bhpq_rsp_if.source  rsp,
	bhpq_cfg_if.sink    cfg
);

	// address, count and child index widths
	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int IW = AW + 2;
	localparam int OW = bhpq_pkg::COUNT_W;

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_UP_RD   = 4'd1;
	localparam logic [3:0] S_UP_CMP  = 4'd2;
	localparam logic [3:0] S_POP_GET = 4'd3;
	localparam logic [3:0] S_DN_RD0  = 4'd4;
	localparam logic [3:0] S_DN_RD1  = 4'd5;
	localparam logic [3:0] S_DN_CMP  = 4'd6;
	localparam logic [3:0] S_PLACE   = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0]                     state_q;
	logic [CW-1:0]                  count_q;
	logic                           order_q;
	logic                           rsp_valid_q;
	bhpq_pkg::rsp_t                 rsp_q;
	logic [bhpq_pkg::STATUS_W-1:0]  status_q;

	// moving element and the hole it travels through
	logic [AW-1:0]                  pos_q;
	bhpq_pkg::value_t               cur_q;
	bhpq_pkg::value_t               lc_q;
	logic                           has_r_q;
	bhpq_pkg::value_t               top_q;

	// heap memory, one write and one registered read per cycle
	bhpq_pkg::value_t               mem [HEAP_DEPTH];
	bhpq_pkg::value_t               rd_data_q;
	logic                           mem_we;
	logic [AW-1:0]                  mem_wa;
	bhpq_pkg::value_t               mem_wd;
	logic                           mem_re;
	logic [AW-1:0]                  mem_ra;

	logic                           req_fire;
	logic                           rsp_free;
	logic [IW-1:0]                  count_x;
	logic [IW-1:0]                  lc_idx;
	logic [IW-1:0]                  rc_idx;
	logic [AW-1:0]                  par_idx;
	logic [CW-1:0]                  last_idx;
	logic                           lc_ok;
	logic                           rc_ok;
	logic                           rc_sel;
	bhpq_pkg::value_t               best_val;
	logic [IW-1:0]                  best_idx;
	logic                           up_move;
	logic                           dn_move;

	// handshakes: items only taken between operations, mode writes always
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// index arithmetic around the hole
	assign count_x  = IW'(count_q);
	assign lc_idx   = IW'({pos_q, 1'b1});
	assign rc_idx   = lc_idx + IW'(1);
	assign par_idx  = AW'((pos_q - AW'(1)) >> 1);
	assign last_idx = count_q - CW'(1);
	assign lc_ok    = lc_idx < count_x;
	assign rc_ok    = rc_idx < count_x;

	// compare logic: child choice feeding the sift-down move decision, and the sift-up move decision
	assign rc_sel   = has_r_q && bhpq_pkg::ranks_above(order_q, rd_data_q, lc_q);
	assign best_val = rc_sel ? rd_data_q : lc_q;
	assign best_idx = rc_sel ? rc_idx : lc_idx;
	assign up_move  = bhpq_pkg::ranks_above(order_q, cur_q, rd_data_q);
	assign dn_move  = bhpq_pkg::ranks_above(order_q, best_val, cur_q);

	// memory port control per state
	always_comb begin
		mem_we = 1'b0;
		mem_wa = pos_q;
		mem_wd = cur_q;
		mem_re = 1'b0;
		mem_ra = par_idx;
		unique case (state_q)
			S_IDLE: begin
				// pop fetches the last element to refill the root
				if (req_fire && req.data.operation == bhpq_pkg::OP_POP && count_q != '0) begin
					mem_re = 1'b1;
					mem_ra = AW'(last_idx);
				end
			end
			S_UP_RD: begin
				if (pos_q != '0) begin
					mem_re = 1'b1;
				end
			end
			S_UP_CMP: begin
				// parent drops into the hole
				if (up_move) begin
					mem_we = 1'b1;
					mem_wd = rd_data_q;
				end
			end
			S_DN_RD0: begin
				if (lc_ok) begin
					mem_re = 1'b1;
					mem_ra = lc_idx[AW-1:0];
				end
			end
			S_DN_RD1: begin
				if (rc_ok) begin
					mem_re = 1'b1;
					mem_ra = rc_idx[AW-1:0];
				end
			end
			S_DN_CMP: begin
				// winning child climbs into the hole
				if (dn_move) begin
					mem_we = 1'b1;
					mem_wd = best_val;
				end
			end
			S_PLACE: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			order_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				order_q <= cfg.order_mode;
			end
			// a new result replaces the one leaving, otherwise the register empties
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						unique case (req.data.operation)
							bhpq_pkg::OP_INSERT: begin
								if (count_q == CW'(HEAP_DEPTH)) begin
									state_q <= S_DONE;
								end else begin
									count_q <= count_q + CW'(1);
									state_q <= S_UP_RD;
								end
							end
							bhpq_pkg::OP_POP: begin
								if (count_q == '0) begin
									state_q <= S_DONE;
								end else begin
									count_q <= last_idx;
									// last element gone: nothing to sift
									state_q <= (last_idx == '0) ? S_DONE : S_POP_GET;
								end
							end
							bhpq_pkg::OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_UP_RD:   state_q <= (pos_q == '0) ? S_PLACE : S_UP_CMP;
				S_UP_CMP:  state_q <= up_move ? S_UP_RD : S_PLACE;
				S_POP_GET: state_q <= S_DN_RD0;
				S_DN_RD0:  state_q <= lc_ok ? S_DN_RD1 : S_PLACE;
				S_DN_RD1:  state_q <= S_DN_CMP;
				S_DN_CMP:  state_q <= dn_move ? S_DN_RD0 : S_PLACE;
				S_PLACE:   state_q <= S_DONE;
				S_DONE: begin
					// hold the result until the output register is free
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// root copy so the result needs no extra memory read
		if (mem_we && mem_wa == '0) begin
			top_q <= mem_wd;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					pos_q <= AW'(count_q);
					cur_q <= req.data.value;
					if (req.data.operation == bhpq_pkg::OP_INSERT && count_q == CW'(HEAP_DEPTH)) begin
						status_q <= bhpq_pkg::ST_FULL;
					end else if (req.data.operation == bhpq_pkg::OP_POP && count_q == '0) begin
						status_q <= bhpq_pkg::ST_EMPTY;
					end else begin
						status_q <= bhpq_pkg::ST_OK;
					end
				end
			end
			S_UP_CMP: begin
				if (up_move) begin
					pos_q <= par_idx;
				end
			end
			S_POP_GET: begin
				cur_q <= rd_data_q;
				pos_q <= '0;
			end
			S_DN_RD1: begin
				lc_q    <= rd_data_q;
				has_r_q <= rc_ok;
			end
			S_DN_CMP: begin
				if (dn_move) begin
					pos_q <= best_idx[AW-1:0];
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_q.top_value <= (count_q != '0) ? top_q : '0;
					rsp_q.count     <= OW'(count_q);
					rsp_q.is_empty  <= (count_q == '0);
					rsp_q.status    <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// element count never runs past the heap size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HEAP_DEPTH))
		else $error("element count beyond heap depth");

	// the heap memory is only written while an operation is in progress
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != S_IDLE && state_q != S_DONE))
		else $error("heap write outside an operation");

	// count only moves when an item is taken
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE || !req_fire) |=> $stable(count_q))
		else $error("element count changed without an item");

	// sift-down reads stay inside the live part of the heap
	a_dn_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re && (state_q == S_DN_RD0 || state_q == S_DN_RD1)) |-> (IW'(mem_ra) < count_x))
		else $error("sift-down read beyond element count");

	// a finished result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && !rsp.ready) |=> state_q == S_DONE)
		else $error("result left done state while output register full");
`endif

endmodule
